[rtl/nrn_pkg.sv]
// Shared constants, payload types and datapath command codes of the neuron block.
package nrn_pkg;

   // Fixed-point format of the activation arithmetic
   localparam int FRAC_BITS   = 16;
   localparam int MAX_WEIGHTS = 256;

   // Field and register widths
   localparam int FIELD_W = 17;                 // Q1.16 value, weight, activation
   localparam int CNT_W   = 9;
   localparam int ACC_W   = 42;                 // Q10.32 running sum
   localparam int THR_W   = 25;
   localparam int STP_W   = 16;
   localparam int SYM_W   = 17;
   localparam int CSR_W   = 3;
   localparam int CSR_D_W = 25;

   // Shared multiplier and divider sizes
   localparam int MOP_W  = 21;
   localparam int MUL_W  = 2 * MOP_W;
   localparam int XMAG_W = 33;
   localparam int U_W    = 36;
   localparam int SP_W   = 34;
   localparam int DIVD_W = 33;
   localparam int DVS_W  = 18;
   localparam int DSTEP_W = 6;

   // Constants
   localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
   localparam logic [CNT_W-1:0]   WC_MAX    = CNT_W'(MAX_WEIGHTS);
   localparam logic [ACC_W-1:0]   ACC_MAX   = '1;
   localparam logic [FIELD_W-1:0] ONE_F     = FIELD_W'(1 << FRAC_BITS);
   localparam logic [15:0]        LN2_F     = 16'd45426;          // round(ln2 * 2^16)
   localparam logic [19:0]        EXP_LIMIT = 20'd772242;         // 17 * LN2_F
   localparam logic [XMAG_W-1:0]  XSAT      = XMAG_W'(64'h1_0000_0000);
   localparam logic [3:0]         I_FIRST   = 4'd8;
   localparam logic [3:0]         K_FIRST   = 4'd3;
   localparam logic [3:0]         K_LAST    = 4'd11;
   localparam logic [DSTEP_W-1:0] DIV_LAST  = DSTEP_W'(DIVD_W - 1);

   // Register indexes of the configuration port
   localparam logic [CSR_W-1:0] CSR_WEIGHT_COUNT = 3'd0;
   localparam logic [CSR_W-1:0] CSR_THRESHOLD    = 3'd1;
   localparam logic [CSR_W-1:0] CSR_STEEPNESS    = 3'd2;
   localparam logic [CSR_W-1:0] CSR_SYMMETRY     = 3'd3;

   typedef struct packed {
      logic [FIELD_W-1:0] value;
      logic [FIELD_W-1:0] weight;
      logic               last;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0] activation;
      logic               count_error;
   } rsp_type;

   // Datapath micro-operations issued by the controller
   typedef enum logic [4:0] {
      OP_NONE,
      OP_MAC_MUL,
      OP_MAC_ADD,
      OP_DIFF,
      OP_XMUL_LO,
      OP_XMUL_HI,
      OP_XSAT,
      OP_EXP_INIT,
      OP_EXP_MUL,
      OP_EXP_DIV,
      OP_EXP_STEP,
      OP_EXP_END,
      OP_LN_DIV,
      OP_LN_W,
      OP_LN_SQ,
      OP_LN_W2,
      OP_LN_MUL,
      OP_LN_DIV2,
      OP_LN_ACC,
      OP_SP,
      OP_YMUL_LO,
      OP_YMUL_HI,
      OP_Y,
      OP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic exp_big;    // exponent argument gives zero
      logic div_busy;
      logic i_one;      // last Horner step
      logic k_last;     // last series term
   } dp_sts_type;

endpackage

[rtl/nrn_div.sv]
// Restoring divider, one quotient bit per cycle.
module nrn_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [nrn_pkg::DIVD_W-1:0]   dividend,
   input  logic [nrn_pkg::DVS_W-1:0]    divisor,
   output logic                         busy,
   output logic [nrn_pkg::DIVD_W-1:0]   quotient
);
   import nrn_pkg::*;

   logic                busy_ff, busy_in;
   logic [DSTEP_W-1:0]  step_ff, step_in;
   logic [DVS_W-1:0]    rem_ff, rem_in;
   logic [DVS_W-1:0]    dvs_ff, dvs_in;
   logic [DIVD_W-1:0]   quo_ff, quo_in;
   logic [DVS_W:0]      trial;
   logic [DVS_W:0]      diff;
   logic                fits;

   // Trial subtraction of one step
   assign trial = {rem_ff, quo_ff[DIVD_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         quo_in  = {quo_ff[DIVD_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == DIV_LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

   // A new division never starts over one in flight
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

endmodule

[rtl/nrn_dp.sv]
// Datapath: configuration, multiply-accumulate and the activation arithmetic.
module nrn_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  nrn_pkg::dp_cmd_type         cmd,
   output nrn_pkg::dp_sts_type         sts,
   input  nrn_pkg::req_type            req_payload,
   input  logic                        csr_valid,
   input  logic [nrn_pkg::CSR_W-1:0]   csr_index,
   input  logic [nrn_pkg::CSR_D_W-1:0] csr_data,
   output nrn_pkg::rsp_type            rsp_payload
);
   import nrn_pkg::*;

   // Configuration
   logic [CNT_W-1:0]  wc_ff, wc_in;
   logic [THR_W-1:0]  thr_ff, thr_in;
   logic [STP_W-1:0]  stp_ff, stp_in;
   logic [SYM_W-1:0]  sym_ff, sym_in;
   // Running state
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   // Working registers
   logic [MUL_W-1:0]  mul_ff, mul_in, lo_ff, lo_in;
   logic [ACC_W-1:0]  dmag_ff, dmag_in;
   logic              xpos_ff, xpos_in;
   logic [XMAG_W-1:0] xmag_ff, xmag_in;
   logic [U_W-1:0]    u_ff, u_in;
   logic [4:0]        n_ff, n_in;
   logic [15:0]       r_ff, r_in;
   logic [FIELD_W-1:0] p_ff, p_in, e_ff, e_in;
   logic [3:0]        i_ff, i_in, k_ff, k_in;
   logic [15:0]       w_ff, w_in, w2_ff, w2_in, term_ff, term_in;
   logic [FIELD_W-1:0] sum_ff, sum_in;
   logic [SP_W-1:0]   sp_ff, sp_in;
   logic [FIELD_W-1:0] act_ff, act_in;
   logic              err_ff, err_in;

   logic [MOP_W-1:0]  mop_a, mop_b;
   logic [STP_W-1:0]  kmag;
   logic [ACC_W:0]    acc_sum;
   logic [ACC_W-1:0]  tq;
   logic              dneg;
   logic [37:0]       xsum;
   logic [34:0]       xval;
   logic [U_W-1:0]    ysum;
   logic [4:0]        nsel;
   logic [FIELD_W-1:0] sym_wr;
   logic              exp_big;
   logic              div_start;
   logic [DIVD_W-1:0] div_dividend, div_q;
   logic [DVS_W-1:0]  div_divisor;
   logic              div_busy;
   logic [3:0]        rdiv;
   logic [MOP_W-1:0]  rcp;
   logic [15:0]       rquo;

   // Slope magnitude (two's complement negate)
   assign kmag = stp_ff[STP_W-1] ? STP_W'(16'd0 - stp_ff) : stp_ff;

   // Reciprocal of the Horner and series divisors: 2^20 / d rounded up, exact for
   // 16-bit dividends
   always_comb begin
      rdiv = (cmd.op == OP_LN_DIV2) ? k_ff : i_ff;
      case (rdiv)
         4'd1:    rcp = 21'd1048576;
         4'd2:    rcp = 21'd524288;
         4'd3:    rcp = 21'd349526;
         4'd4:    rcp = 21'd262144;
         4'd5:    rcp = 21'd209716;
         4'd6:    rcp = 21'd174763;
         4'd7:    rcp = 21'd149797;
         4'd8:    rcp = 21'd131072;
         4'd9:    rcp = 21'd116509;
         4'd10:   rcp = 21'd104858;
         4'd11:   rcp = 21'd95326;
         default: rcp = '0;
      endcase
   end

   // Quotient of the reciprocal multiply
   assign rquo = mul_ff[35:20];

   // Shared multiplier operand selection
   always_comb begin
      case (cmd.op)
         OP_MAC_MUL: begin
            mop_a = MOP_W'(req_payload.value);
            mop_b = MOP_W'(req_payload.weight);
         end
         OP_XMUL_LO: begin
            mop_a = MOP_W'(kmag);
            mop_b = dmag_ff[20:0];
         end
         OP_XMUL_HI: begin
            mop_a = MOP_W'(kmag);
            mop_b = dmag_ff[41:21];
         end
         OP_EXP_MUL: begin
            mop_a = MOP_W'(r_ff);
            mop_b = MOP_W'(p_ff);
         end
         OP_EXP_DIV, OP_LN_DIV2: begin
            mop_a = MOP_W'(mul_ff[31:16]);
            mop_b = rcp;
         end
         OP_LN_SQ: begin
            mop_a = MOP_W'(w_ff);
            mop_b = MOP_W'(w_ff);
         end
         OP_LN_MUL: begin
            mop_a = MOP_W'(term_ff);
            mop_b = MOP_W'(w2_ff);
         end
         OP_YMUL_LO: begin
            mop_a = MOP_W'(sym_ff);
            mop_b = MOP_W'(sp_ff[16:0]);
         end
         OP_YMUL_HI: begin
            mop_a = MOP_W'(sym_ff);
            mop_b = MOP_W'(sp_ff[33:17]);
         end
         default: begin
            mop_a = '0;
            mop_b = '0;
         end
      endcase
   end

   assign mul_in = mop_a * mop_b;

   // Helper terms
   assign acc_sum = {1'b0, acc_ff} + (ACC_W + 1)'(mul_ff[33:0]);
   assign tq      = ACC_W'({thr_ff, 16'd0});
   assign dneg    = acc_ff < tq;
   assign xsum    = 38'(mul_ff[36:0]) + 38'(lo_ff[41:21]);
   assign xval    = xsum[37:3];
   assign ysum    = U_W'({mul_ff[33:0], 1'b0}) + U_W'(lo_ff[41:16]);
   assign exp_big = u_ff >= U_W'(EXP_LIMIT);
   assign sym_wr  = (csr_data[16:0] > ONE_F) ? ONE_F : csr_data[16:0];

   // Range reduction: n = floor(u / ln2) by compare against multiples
   always_comb begin
      nsel = '0;
      for (int k = 1; k <= 16; k++) begin
         if (u_ff >= U_W'(k * 45426)) begin
            nsel = 5'(k);
         end
      end
   end

   // Divider operand selection
   always_comb begin
      div_start = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      case (cmd.op)
         OP_LN_DIV: begin
            div_start    = 1'b1;
            div_dividend = {e_ff, 16'd0};
            div_divisor  = DVS_W'({ONE_F, 1'b0}) + DVS_W'(e_ff);
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   nrn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_q)
   );

   // Next-state of the working registers
   always_comb begin
      wc_in   = wc_ff;
      thr_in  = thr_ff;
      stp_in  = stp_ff;
      sym_in  = sym_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      lo_in   = lo_ff;
      dmag_in = dmag_ff;
      xpos_in = xpos_ff;
      xmag_in = xmag_ff;
      u_in    = u_ff;
      n_in    = n_ff;
      r_in    = r_ff;
      p_in    = p_ff;
      e_in    = e_ff;
      i_in    = i_ff;
      k_in    = k_ff;
      w_in    = w_ff;
      w2_in   = w2_ff;
      term_in = term_ff;
      sum_in  = sum_ff;
      sp_in   = sp_ff;
      act_in  = act_ff;
      err_in  = err_ff;

      // configuration write
      if (csr_valid) begin
         case (csr_index)
            CSR_WEIGHT_COUNT: wc_in  = csr_data[CNT_W-1:0];
            CSR_THRESHOLD:    thr_in = csr_data[THR_W-1:0];
            CSR_STEEPNESS:    stp_in = csr_data[STP_W-1:0];
            CSR_SYMMETRY:     sym_in = sym_wr;
            default:          wc_in  = wc_ff;
         endcase
      end

      case (cmd.op)
         OP_MAC_ADD: begin
            acc_in = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
            if (cnt_ff != CNT_MAX) begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         OP_DIFF: begin
            dmag_in = dneg ? tq - acc_ff : acc_ff - tq;
            xpos_in = (dneg != stp_ff[STP_W-1]) && (acc_ff != tq) && (kmag != '0);
         end
         OP_XMUL_HI: begin
            lo_in = mul_ff;
         end
         OP_XSAT: begin
            xmag_in = (xval > 35'(XSAT)) ? XSAT : xval[XMAG_W-1:0];
            u_in    = (xval > 35'(XSAT)) ? U_W'(XSAT) : U_W'(xval);
         end
         OP_EXP_INIT: begin
            n_in = nsel;
            r_in = 16'(u_ff[19:0] - 20'(nsel) * 20'(LN2_F));
            p_in = ONE_F;
            i_in = I_FIRST;
         end
         OP_EXP_STEP: begin
            p_in = ONE_F - FIELD_W'(rquo);
            i_in = i_ff - 1'b1;
         end
         OP_EXP_END: begin
            e_in = exp_big ? '0 : (p_ff >> n_ff);
         end
         OP_LN_W: begin
            w_in = div_q[15:0];
         end
         OP_LN_W2: begin
            w2_in   = mul_ff[31:16];
            term_in = w_ff;
            sum_in  = FIELD_W'(w_ff);
            k_in    = K_FIRST;
         end
         OP_LN_DIV2: begin
            term_in = mul_ff[31:16];
         end
         OP_LN_ACC: begin
            sum_in = sum_ff + FIELD_W'(rquo);
            k_in   = k_ff + 4'd2;
         end
         OP_SP: begin
            sp_in = SP_W'({sum_ff, 1'b0}) + (xpos_ff ? SP_W'(xmag_ff) : '0);
         end
         OP_YMUL_HI: begin
            lo_in = mul_ff;
         end
         OP_Y: begin
            u_in = ysum;
         end
         OP_OUT: begin
            act_in = (e_ff > ONE_F) ? ONE_F : e_ff;
            err_in = (cnt_ff != wc_ff) || (wc_ff == '0) || (wc_ff > WC_MAX);
            acc_in = '0;
            cnt_in = '0;
         end
         default: begin
            lo_in = lo_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wc_ff  <= CNT_W'(1);
         thr_ff <= '0;
         stp_ff <= STP_W'(256);
         sym_ff <= ONE_F;
         acc_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wc_ff  <= wc_in;
         thr_ff <= thr_in;
         stp_ff <= stp_in;
         sym_ff <= sym_in;
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
      end
      mul_ff  <= mul_in;
      lo_ff   <= lo_in;
      dmag_ff <= dmag_in;
      xpos_ff <= xpos_in;
      xmag_ff <= xmag_in;
      u_ff    <= u_in;
      n_ff    <= n_in;
      r_ff    <= r_in;
      p_ff    <= p_in;
      e_ff    <= e_in;
      i_ff    <= i_in;
      k_ff    <= k_in;
      w_ff    <= w_in;
      w2_ff   <= w2_in;
      term_ff <= term_in;
      sum_ff  <= sum_in;
      sp_ff   <= sp_in;
      act_ff  <= act_in;
      err_ff  <= err_in;
   end

   // Status to the controller
   assign sts.exp_big  = exp_big;
   assign sts.div_busy = div_busy;
   assign sts.i_one    = (i_ff == 4'd1);
   assign sts.k_last   = (k_ff == K_LAST);

   assign rsp_payload.activation  = act_ff;
   assign rsp_payload.count_error = err_ff;

   // Series divisor stays on the odd terms three to eleven
   a_k_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_LN_ACC) |-> (k_ff[0] && (k_ff <= K_LAST) && (k_ff >= K_FIRST)))
      else $error("series index out of range");

endmodule

[rtl/nrn_ctrl.sv]
// Controller: sequences accumulation, activation evaluation and the result register.
module nrn_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output nrn_pkg::dp_cmd_type cmd,
   input  nrn_pkg::dp_sts_type sts
);
   import nrn_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE, ST_MAC, ST_DIFF, ST_XLO, ST_XHI, ST_XSAT,
      ST_EINIT, ST_EMUL, ST_EDIV, ST_ESTEP, ST_EEND,
      ST_LDIV, ST_LWAIT, ST_LW, ST_LSQ, ST_LW2, ST_LMUL, ST_LDIV2, ST_LACC,
      ST_SP, ST_YLO, ST_YHI, ST_Y, ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      last_ff, last_in;
   logic      second_ff, second_in;     // second pass of the exponential
   logic      rsp_valid_ff, rsp_valid_in;
   dp_op_type op;

   // Next state and micro-operation
   always_comb begin
      state_in     = state_ff;
      last_in      = last_ff;
      second_in    = second_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      op           = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            op = OP_MAC_MUL;
            if (req_valid) begin
               last_in  = req_last;
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            op       = OP_MAC_ADD;
            state_in = last_ff ? ST_DIFF : ST_IDLE;
         end
         ST_DIFF: begin
            op       = OP_DIFF;
            state_in = ST_XLO;
         end
         ST_XLO: begin
            op       = OP_XMUL_LO;
            state_in = ST_XHI;
         end
         ST_XHI: begin
            op       = OP_XMUL_HI;
            state_in = ST_XSAT;
         end
         ST_XSAT: begin
            op        = OP_XSAT;
            second_in = 1'b0;
            state_in  = ST_EINIT;
         end
         ST_EINIT: begin
            op       = OP_EXP_INIT;
            state_in = sts.exp_big ? ST_EEND : ST_EMUL;
         end
         ST_EMUL: begin
            op       = OP_EXP_MUL;
            state_in = ST_EDIV;
         end
         ST_EDIV: begin
            // divide by the Horner index through its reciprocal
            op       = OP_EXP_DIV;
            state_in = ST_ESTEP;
         end
         ST_ESTEP: begin
            op       = OP_EXP_STEP;
            state_in = sts.i_one ? ST_EEND : ST_EMUL;
         end
         ST_EEND: begin
            op       = OP_EXP_END;
            state_in = second_ff ? ST_OUT : ST_LDIV;
         end
         ST_LDIV: begin
            op       = OP_LN_DIV;
            state_in = ST_LWAIT;
         end
         ST_LWAIT: begin
            if (!sts.div_busy) begin
               state_in = ST_LW;
            end
         end
         ST_LW: begin
            op       = OP_LN_W;
            state_in = ST_LSQ;
         end
         ST_LSQ: begin
            op       = OP_LN_SQ;
            state_in = ST_LW2;
         end
         ST_LW2: begin
            op       = OP_LN_W2;
            state_in = ST_LMUL;
         end
         ST_LMUL: begin
            op       = OP_LN_MUL;
            state_in = ST_LDIV2;
         end
         ST_LDIV2: begin
            // divide the series term through the reciprocal of its index
            op       = OP_LN_DIV2;
            state_in = ST_LACC;
         end
         ST_LACC: begin
            op       = OP_LN_ACC;
            state_in = sts.k_last ? ST_SP : ST_LMUL;
         end
         ST_SP: begin
            op       = OP_SP;
            state_in = ST_YLO;
         end
         ST_YLO: begin
            op       = OP_YMUL_LO;
            state_in = ST_YHI;
         end
         ST_YHI: begin
            op       = OP_YMUL_HI;
            state_in = ST_Y;
         end
         ST_Y: begin
            op        = OP_Y;
            second_in = 1'b1;
            state_in  = ST_EINIT;
         end
         ST_OUT: begin
            // load the result once the previous one has been taken
            if (!rsp_valid_ff || !rsp_stall) begin
               op           = OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_ff      <= 1'b0;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign cmd.op    = op;

   // No exponential starts while a division is still running
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EINIT) |-> !sts.div_busy)
      else $error("exponential started with divider busy");

   // A result only appears from the output state
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside output state");

endmodule

[rtl/neuron_dot_product_richards_activation.sv]
// Top level of the neuron: dot product with a generalised logistic activation.
//
// Input channel (req_): one value/weight pair per transfer, both Q1.16 in 0 to 1;
// req_payload.last marks the final element of a vector. Each element is
// multiplied, then accumulated with saturation; req_stall is high while it accumulates.
// Result channel (rsp_): one transfer per vector, activation in Q1.16 and a
// count_error flag when the element count is not weight_count, or weight_count is 0 or above 256.
// After the last element the activation is evaluated by the controller on a
// shared multiplier before rsp_valid rises. The log series uses the
// one-bit-a-cycle divider, and each exponential uses Horner divisions by
// reciprocal multiply; the Horner steps of an exponential whose argument is
// out of range are skipped.
// The result sits in an output register; new elements are accepted while it
// waits. If the receiver stalls, a second finished vector waits in the
// controller until the first result has been transferred.
// Configuration (csr_): index/data writes, always ready; write only while idle.
// Reset (synchronous, active high) restores the default registers and clears
// the accumulator, the element count and the result valid flag.
module neuron_dot_product_richards_activation (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  nrn_pkg::req_type            req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output nrn_pkg::rsp_type            rsp_payload,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [nrn_pkg::CSR_W-1:0]   csr_index,
   input  logic [nrn_pkg::CSR_D_W-1:0] csr_data
);
   import nrn_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   assign csr_ready = 1'b1;

   nrn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_payload.last),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   nrn_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_payload (req_payload),
      .csr_valid   (csr_valid & csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_payload (rsp_payload)
   );

endmodule

[tb/tb_top.sv]
// Self-checking testbench of the neuron block: dot product and generalised logistic output.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import nrn_pkg::*;

   // Register index that the block does not implement
   localparam logic [CSR_W-1:0] CSR_UNUSED = 3'd5;

   // Bit-accurate prediction of the neuron, one expected response per vector
   class neuron_scoreboard;
      logic [8:0]   wcount;
      logic [24:0]  thresh;
      logic [15:0]  slope;
      logic [16:0]  sym;
      logic [63:0]  sum_q32;
      logic [8:0]   elems;
      rsp_type      expected_rsps[$];
      int           errors;
      int           results;

      function new();
         wcount = 9'd1; thresh = '0; slope = 16'd256; sym = 17'd65536;
         sum_q32 = '0; elems = '0; errors = 0; results = 0;
      endfunction

      function void report(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         errors++;
      endfunction

      // exp(-u) in Q.16: range reduction by ln2 then degree-8 Horner
      function logic [63:0] exp_neg(logic [63:0] u);
         logic [63:0] n, r, p;
         n = u / 64'd45426;
         r = u - n * 64'd45426;
         p = 64'd65536;
         if (n > 64'd16) return 64'd0;
         for (int i = 8; i >= 1; i--)
            p = 64'd65536 - ((r * p) >> 16) / i;
         return p >> n;
      endfunction

      // ln(1+z) by the atanh series in odd powers of w
      function logic [63:0] ln_one_plus(logic [63:0] z);
         logic [63:0] w, w2, term, acc;
         w = (z << 16) / (64'd131072 + z);
         w2 = (w * w) >> 16;
         term = w;
         acc = w;
         for (int k = 3; k <= 11; k += 2) begin
            term = (term * w2) >> 16;
            acc += term / k;
         end
         return 2 * acc;
      endfunction

      function logic [16:0] activation_of_sum();
         logic [63:0] tq, dmag, kmag, xmag, sp, y, e;
         logic dneg, kneg, xpos;
         tq = 64'(thresh) << 16;
         dneg = sum_q32 < tq;
         dmag = dneg ? tq - sum_q32 : sum_q32 - tq;
         kneg = slope[15];
         kmag = kneg ? 64'd65536 - 64'(slope) : 64'(slope);
         xpos = (dneg != kneg) && dmag != 0 && kmag != 0;
         xmag = (kmag * dmag) >> 24;
         if (xmag > 64'h1_0000_0000) xmag = 64'h1_0000_0000;
         sp = ln_one_plus(exp_neg(xmag));
         if (xpos) sp += xmag;
         y = (64'(sym) * sp) >> 16;
         e = exp_neg(y);
         if (e > 64'd65536) e = 64'd65536;
         return e[16:0];
      endfunction

      function void write_reg(logic [CSR_W-1:0] idx, logic [CSR_D_W-1:0] data);
         case (idx)
            CSR_WEIGHT_COUNT: wcount = data[8:0];
            CSR_THRESHOLD:    thresh = data;
            CSR_STEEPNESS:    slope = data[15:0];
            CSR_SYMMETRY: begin
               sym = data[16:0];
               if (sym > 17'd65536) sym = 17'd65536;
            end
            default: ;
         endcase
      endfunction

      // Accepted element: accumulate, and on the last one predict the response
      function void note_element(req_type rq);
         rsp_type exp_rsp;
         sum_q32 += 64'(rq.value) * 64'(rq.weight);
         if (sum_q32 > 64'h3FF_FFFF_FFFF) sum_q32 = 64'h3FF_FFFF_FFFF;
         if (elems != CNT_MAX) elems++;
         if (rq.last) begin
            exp_rsp.activation  = activation_of_sum();
            exp_rsp.count_error = (elems != wcount) || wcount == 0 || wcount > WC_MAX;
            expected_rsps = {expected_rsps, exp_rsp};
            sum_q32 = '0;
            elems = '0;
         end
      endfunction

      function void check_rsp(rsp_type got);
         rsp_type want;
         results++;
         if (expected_rsps.size() == 0) begin
            report("response with no vector outstanding");
            return;
         end
         want = expected_rsps.pop_front();
         if (got.activation !== want.activation)
            report($sformatf("activation %0d, expected %0d", got.activation, want.activation));
         if (got.count_error !== want.count_error)
            report($sformatf("count_error %0b, expected %0b",
                             got.count_error, want.count_error));
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_payload = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_payload;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CSR_W-1:0]    csr_index = '0;
   logic [CSR_D_W-1:0]  csr_data = '0;

   neuron_dot_product_richards_activation DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   neuron_scoreboard sb = new();
   int   tx_idle_pct = 0;
   int   rx_idle_pct = 0;
   int   elems_sent = 0;
   int   quiet_cycles = 0;
   int   vectors_sent = 0;

   always #1 clock = ~clock;

   // Monitor: every transfer seen at the edge updates or checks the prediction
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
         if (req_valid && !req_stall) sb.note_element(req_payload);
         if (rsp_valid && !rsp_stall) sb.check_rsp(rsp_payload);
      end
   end

   // Receiver back-pressure
   always @(posedge clock)
      rsp_stall <= !reset && ($urandom_range(99) < rx_idle_pct);

   // Watchdog on cycles without any element or result transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("Timeout: no transfer for %0d cycles", quiet_cycles);
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic write_csr(logic [CSR_W-1:0] idx, logic [CSR_D_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_element(logic [16:0] v, logic [16:0] w, logic lst);
      req_type rq;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      rq.value = v; rq.weight = w; rq.last = lst;
      req_valid   <= 1'b1;
      req_payload <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      elems_sent++;
   endtask

   function automatic logic [16:0] pick_q16();
      case ($urandom_range(7))
         0: return 17'd0;
         1: return 17'd65536;
         2: return 17'd65535;
         default: return 17'($urandom_range(65536));
      endcase
   endfunction

   // One vector; with full set every element is 1.0 x 1.0
   task automatic send_vector(int len, bit full);
      for (int i = 0; i < len; i++) begin
         if (full) send_element(17'd65536, 17'd65536, i == len - 1);
         else send_element(pick_q16(), pick_q16(), i == len - 1);
      end
      vectors_sent++;
   endtask

   // Idle between phases: drain responses, then let the datapath settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_rsps.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic configure(int wc, int thr, logic [CSR_D_W-1:0] stp, int sy);
      write_csr(CSR_WEIGHT_COUNT, CSR_D_W'(wc));
      write_csr(CSR_THRESHOLD, CSR_D_W'(thr));
      write_csr(CSR_STEEPNESS, stp);
      write_csr(CSR_SYMMETRY, CSR_D_W'(sy));
   endtask

   initial begin
      int wc, len;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset settings, extremes of the fields, wrong counts
      tx_idle_pct = 24; rx_idle_pct = 68;
      send_element(17'd0, 17'd0, 1'b1);
      send_element(17'd65536, 17'd65536, 1'b1);
      send_element(17'd65536, 17'd0, 1'b1);
      send_element(17'd0, 17'd65536, 1'b1);
      send_element(17'd65535, 17'd43690, 1'b1);
      send_vector(2, 1'b0);
      send_vector(3, 1'b1);
      drain();

      // Full-scale weight count, threshold at the largest possible sum, steepest positive slope
      configure(256, 16777216, CSR_D_W'(16'h7FFF), 65536);
      send_vector(256, 1'b1);
      send_vector(1, 1'b0);
      drain();

      // Zero weight count is always an error; steepest negative slope, no asymmetry
      configure(0, 0, {9'h1AB, 16'h8000}, 0);
      write_csr(CSR_UNUSED, '1);
      send_vector(1, 1'b0);
      send_vector(4, 1'b1);
      drain();

      // Count above the limit; counter saturation; symmetry above one is clipped
      configure(511, 65536, CSR_D_W'(16'hFFFF), 131071);
      send_vector(515, 1'b1);
      send_vector(2, 1'b0);
      drain();

      // Random phases under the three idling schemes
      for (int ph = 0; elems_sent < 1650; ph++) begin
         if (ph < 2) begin
            tx_idle_pct = 24; rx_idle_pct = 68;
         end else if (ph < 4) begin
            tx_idle_pct = 68; rx_idle_pct = 24;
         end else begin
            tx_idle_pct = 0; rx_idle_pct = 0;
         end
         wc = ($urandom_range(9) == 0) ? $urandom_range(17, 300) : $urandom_range(1, 16);
         configure(wc, (ph % 4 == 0) ? 0 : $urandom_range(0, (wc > 256 ? 256 : wc) * 65536),
                   CSR_D_W'($urandom), $urandom_range(0, 70000));
         for (int n = 0; n < 120; n += len) begin
            if ($urandom_range(9) < 8 && wc <= 20) len = wc;
            else len = $urandom_range(1, 20);
            send_vector(len, $urandom_range(15) == 0);
         end
         drain();
      end

      repeat (100) @(posedge clock);
      $display("Covered %0d elements in %0d vectors, %0d responses checked.",
               elems_sent, vectors_sent, sb.results);
      $display("Register extremes, invalid counts and saturating counter exercised.");
      if (sb.errors == 0 && sb.expected_rsps.size() == 0)
         $display("DONE: 0 errors");
      else begin
         if (sb.expected_rsps.size() != 0)
            sb.report($sformatf("%0d responses never arrived", sb.expected_rsps.size()));
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
